@@ rtl/core/tcw_pkg.sv @@
// tcw_pkg: shared types, codes and defaults for the text console writer
// no dependencies
package tcw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam int CHAR_W      = 8;
  localparam int CELL_W      = 2 * CHAR_W;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int ROW_FIELD_W = 5;
  localparam int COL_FIELD_W = 7;

  localparam logic [CHAR_W-1:0] CODE_NEWLINE     = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_RETURN      = 8'd13;
  localparam logic [CHAR_W-1:0] CODE_SPACE       = 8'h20;
  localparam logic [CHAR_W-1:0] RST_TEXT_ATTR    = 8'h07;
  localparam logic [CHAR_W-1:0] RST_CURSOR_ATTR  = 8'h0F;
  localparam logic [CHAR_W-1:0] RST_CURSOR_GLYPH = 8'h5F;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT       = 2'd0,
    MODE_BACKSPACE = 2'd1,
    MODE_CLEAR     = 2'd2,
    MODE_READ      = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEXT_ATTR    = 2'd0,
    CFG_CURSOR_ATTR  = 2'd1,
    CFG_CURSOR_GLYPH = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_SCROLL_RD,
    ST_SCROLL_WR,
    ST_ERASE,
    ST_READ,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [CHAR_W-1:0] text_attr;
    logic [CHAR_W-1:0] cursor_attr;
    logic [CHAR_W-1:0] cursor_glyph;
  } cfg_t;

  typedef struct packed {
    logic [CHAR_W-1:0]      cell_char;
    logic [CHAR_W-1:0]      cell_attr;
    logic [COL_FIELD_W-1:0] cursor_col;
    logic [ROW_FIELD_W-1:0] cursor_row;
    logic                   scrolled;
  } res_t;

endpackage

@@ rtl/core/tcw_store.sv @@
// tcw_store: screen store, one write port and one registered read port
// depends on tcw_pkg
module tcw_store
  import tcw_pkg::*;
#(
  parameter int DEPTH  = DEF_ROWS * DEF_COLUMNS,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [CELL_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [CELL_W-1:0] rdata_o
);

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/tcw_ctrl.sv @@
// tcw_ctrl: command sequencer, cursor and the shared address unit
// that walks the screen store for clear, scroll and fill
// depends on tcw_pkg
module tcw_ctrl
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS,
  parameter int CELLS   = ROWS * COLUMNS,
  parameter int ADDR_W  = $clog2(CELLS),
  parameter int COL_W   = $clog2(COLUMNS),
  parameter int ROW_W   = $clog2(ROWS)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [MODE_W-1:0]      mode_i,
  input  logic [CHAR_W-1:0]      char_code_i,
  input  logic [ROW_FIELD_W-1:0] read_row_i,
  input  logic [COL_FIELD_W-1:0] read_col_i,
  input  logic                   out_free_i,
  output logic                   res_valid_o,
  output res_t                   res_o,
  output logic                   we_o,
  output logic [ADDR_W-1:0]      waddr_o,
  output logic [CELL_W-1:0]      wdata_o,
  output logic                   re_o,
  output logic [ADDR_W-1:0]      raddr_o,
  input  logic [CELL_W-1:0]      rdata_i
);

  localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] LAST_MOVE   = ADDR_W'(CELLS - COLUMNS - 1);
  localparam logic [ADDR_W-1:0] BOTTOM_BASE = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STEP    = ADDR_W'(COLUMNS);
  localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic [CHAR_W-1:0] fill_attr_q, fill_attr_d;
  logic              init_q, init_d;
  logic [CHAR_W-1:0] res_char_q, res_char_d;
  logic [CHAR_W-1:0] res_attr_q, res_attr_d;
  logic              scrolled_q, scrolled_d;

  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] read_addr;
  logic              read_in_range;
  logic              read_at_cursor;
  logic [CELL_W-1:0] blank;

  assign cur_addr       = base_q + ADDR_W'(col_q);
  assign read_addr      = ADDR_W'(read_row_i) * ROW_STEP + ADDR_W'(read_col_i);
  assign read_in_range  = (int'(read_row_i) < ROWS) && (int'(read_col_i) < COLUMNS);
  assign read_at_cursor = (int'(read_row_i) == int'(row_q)) &&
                          (int'(read_col_i) == int'(col_q));
  assign blank          = {cfg_i.text_attr, CODE_SPACE};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      addr_q      <= '0;
      col_q       <= '0;
      row_q       <= '0;
      base_q      <= '0;
      fill_attr_q <= RST_TEXT_ATTR;
      init_q      <= 1'b1;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      col_q       <= col_d;
      row_q       <= row_d;
      base_q      <= base_d;
      fill_attr_q <= fill_attr_d;
      init_q      <= init_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_char_q <= res_char_d;
    res_attr_q <= res_attr_d;
    scrolled_q <= scrolled_d;
  end

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    col_d       = col_q;
    row_d       = row_q;
    base_d      = base_q;
    fill_attr_d = fill_attr_q;
    init_d      = init_q;
    res_char_d  = res_char_q;
    res_attr_d  = res_attr_q;
    scrolled_d  = scrolled_q;
    we_o        = 1'b0;
    waddr_o     = cur_addr;
    wdata_o     = blank;
    re_o        = 1'b0;
    raddr_o     = read_addr;
    res_valid_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          res_char_d = '0;
          res_attr_d = '0;
          scrolled_d = 1'b0;
          state_d    = ST_DONE;
          case (mode_e'(mode_i))
            MODE_PUT: begin
              if (char_code_i == CODE_RETURN) begin
                col_d = '0;
              end else begin
                if (char_code_i != CODE_NEWLINE) begin
                  we_o    = 1'b1;
                  wdata_o = {cfg_i.text_attr, char_code_i};
                end
                if (char_code_i != CODE_NEWLINE && col_q != LAST_COL) begin
                  col_d = col_q + COL_W'(1);
                end else begin
                  col_d = '0;
                  if (row_q == LAST_ROW) begin
                    // bottom passed: move every row up
                    row_d       = LAST_ROW;
                    base_d      = BOTTOM_BASE;
                    addr_d      = '0;
                    fill_attr_d = cfg_i.text_attr;
                    scrolled_d  = 1'b1;
                    state_d     = ST_SCROLL_RD;
                  end else begin
                    row_d  = row_q + ROW_W'(1);
                    base_d = base_q + ROW_STEP;
                  end
                end
              end
            end
            MODE_BACKSPACE: begin
              if (col_q != '0) begin
                col_d   = col_q - COL_W'(1);
                state_d = ST_ERASE;
              end else if (row_q != '0) begin
                col_d   = LAST_COL;
                row_d   = row_q - ROW_W'(1);
                base_d  = base_q - ROW_STEP;
                state_d = ST_ERASE;
              end
            end
            MODE_CLEAR: begin
              col_d       = '0;
              row_d       = '0;
              base_d      = '0;
              addr_d      = '0;
              fill_attr_d = cfg_i.text_attr;
              state_d     = ST_FILL;
            end
            MODE_READ: begin
              if (read_in_range) begin
                if (read_at_cursor) begin
                  res_char_d = cfg_i.cursor_glyph;
                  res_attr_d = cfg_i.cursor_attr;
                end else begin
                  re_o    = 1'b1;
                  state_d = ST_READ;
                end
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_FILL: begin
        we_o    = 1'b1;
        waddr_o = addr_q;
        wdata_o = {fill_attr_q, CODE_SPACE};
        if (addr_q == LAST_CELL) begin
          if (init_q) begin
            init_d  = 1'b0;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_DONE;
          end
        end else begin
          addr_d = addr_q + ADDR_W'(1);
        end
      end
      ST_SCROLL_RD: begin
        re_o    = 1'b1;
        raddr_o = addr_q + ROW_STEP;
        state_d = ST_SCROLL_WR;
      end
      ST_SCROLL_WR: begin
        we_o    = 1'b1;
        waddr_o = addr_q;
        wdata_o = rdata_i;
        if (addr_q == LAST_MOVE) begin
          addr_d  = BOTTOM_BASE;
          state_d = ST_FILL;
        end else begin
          addr_d  = addr_q + ADDR_W'(1);
          state_d = ST_SCROLL_RD;
        end
      end
      ST_ERASE: begin
        we_o    = 1'b1;
        state_d = ST_DONE;
      end
      ST_READ: begin
        res_char_d = rdata_i[CHAR_W-1:0];
        res_attr_d = rdata_i[CELL_W-1:CHAR_W];
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign res_o.cell_char  = res_char_q;
  assign res_o.cell_attr  = res_attr_q;
  assign res_o.cursor_col = COL_FIELD_W'(col_q);
  assign res_o.cursor_row = ROW_FIELD_W'(row_q);
  assign res_o.scrolled   = scrolled_q;

endmodule

@@ rtl/core/text_console_writer.sv @@
// text_console_writer: character cell console for put, backspace, clear and read words;
// clear walks the whole store, and a scroll walks it through the address unit, reading each
// cell of the row below and writing it one row up; one word at a time, so no new word is
// taken before the last one's result is handed on. After reset a fill pass writes blanks
// with attribute 0x07 while input is stalled.
// depends on tcw_pkg, tcw_ctrl, tcw_store
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CHAR_W-1:0]      cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [MODE_W-1:0]      mode_i,
  input  logic [CHAR_W-1:0]      char_code_i,
  input  logic [ROW_FIELD_W-1:0] read_row_i,
  input  logic [COL_FIELD_W-1:0] read_col_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [CHAR_W-1:0]      cell_char_o,
  output logic [CHAR_W-1:0]      cell_attr_o,
  output logic [COL_FIELD_W-1:0] cursor_col_o,
  output logic [ROW_FIELD_W-1:0] cursor_row_o,
  output logic                   scrolled_o
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);

  cfg_t              cfg_q;
  logic              out_valid_q;
  res_t              out_q;
  logic              out_free;
  logic              res_valid;
  res_t              res;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic [CELL_W-1:0] rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.text_attr    <= RST_TEXT_ATTR;
      cfg_q.cursor_attr  <= RST_CURSOR_ATTR;
      cfg_q.cursor_glyph <= RST_CURSOR_GLYPH;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TEXT_ATTR:    cfg_q.text_attr    <= cfg_data_i;
        CFG_CURSOR_ATTR:  cfg_q.cursor_attr  <= cfg_data_i;
        CFG_CURSOR_GLYPH: cfg_q.cursor_glyph <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // output word register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .char_code_i (char_code_i),
    .read_row_i  (read_row_i),
    .read_col_i  (read_col_i),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  tcw_store #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign cell_char_o  = out_q.cell_char;
  assign cell_attr_o  = out_q.cell_attr;
  assign cursor_col_o = out_q.cursor_col;
  assign cursor_row_o = out_q.cursor_row;
  assign scrolled_o   = out_q.scrolled;

endmodule
